>>> hdl/tela_pkg.sv
// Shared types, constants and helpers for the terminal line assembler.
`default_nettype none
package tela_pkg;
  localparam int LINE_CAP = 64;
  localparam int AW       = $clog2(LINE_CAP);
  localparam int MARK_LEN = 10;
  localparam int KEEP_MAX = LINE_CAP - 1 - MARK_LEN;

  localparam logic [7:0] CH_ESC = 8'h1b;
  localparam logic [7:0] CH_DEL = 8'h7f;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_BS  = 8'h08;

  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;

  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    MODE_NORMAL, MODE_ESC, MODE_CSI, MODE_OSC, MODE_OSC_ESC
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EMIT_RD, S_EMIT_PUSH, S_SINGLE, S_POST, S_MV_RD, S_MV_WR, S_FILL
  } seq_t;

  // " [wrapped]"
  function automatic logic [7:0] wrap_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = " ";
      4'd1:    ch = "[";
      4'd2:    ch = "w";
      4'd3:    ch = "r";
      4'd4:    ch = "a";
      4'd5:    ch = "p";
      4'd6:    ch = "p";
      4'd7:    ch = "e";
      4'd8:    ch = "d";
      4'd9:    ch = "]";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction
endpackage
`default_nettype wire

>>> hdl/tela_line_ram.sv
// Line store: one write port, one read port with registered read data.
`default_nettype none
module tela_line_ram (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [tela_pkg::AW-1:0] waddr,
  input  wire logic [7:0]            wdata,
  input  wire logic [tela_pkg::AW-1:0] raddr,
  output logic      [7:0]            rdata
);
  logic [7:0] mem [tela_pkg::LINE_CAP];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hdl/terminal_escape_line_assembler.sv
// Each emitted character is read in S_EMIT_RD and sent in S_EMIT_PUSH, which waits while the
// output is held; CSI P and @ move the tail through S_MV_RD and S_MV_WR, and blanks are
// written at 1 per cycle. Throughput is set by the registered read of the line store, walked
// one entry at a time. Reset is synchronous and clears all control state; the line store is
// not cleared and needs no clearing pass (only entries below the line length are read).
`default_nettype none
module terminal_escape_line_assembler (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tuser,   // [0] command
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic      [7:0] m_tdata,   // [7:0] line_char
  output logic      [1:0] m_tuser,   // [1:0] kind
  output logic            m_tlast,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data
);
  localparam int AW = tela_pkg::AW;

  tela_pkg::seq_t  state, state_next;
  tela_pkg::mode_t mode, mode_next;
  logic [AW-1:0] len, len_next, cur, cur_next;
  logic left, left_next;
  logic [15:0] num, num_next;
  logic more, more_next, priv, priv_next;
  logic fs_en;
  logic [AW-1:0] e, e_next, em_total, em_total_next, em_keep, em_keep_next;
  logic pend, pend_next;
  logic [7:0] pend_char, pend_char_next;
  logic [1:0] single_kind, single_kind_next;
  logic [AW-1:0] mv_rd, mv_rd_next, mv_wr, mv_wr_next, mv_cnt, mv_cnt_next;
  logic mv_dir, mv_dir_next;
  logic [AW-1:0] fl_ptr, fl_ptr_next, fl_cnt, fl_cnt_next;
  logic out_valid, out_valid_next, out_last, out_last_next;
  logic [7:0] out_char, out_char_next;
  logic [1:0] out_kind, out_kind_next;

  logic acc, out_free;
  logic [7:0] c;
  logic [AW-1:0] cur_f, len_f, tail;
  logic [15:0] nn, nm1;
  logic [16:0] sumc;
  logic [19:0] prod;
  logic [AW-1:0] np, ni, nx, room;
  logic is_print, ovf, put_direct;
  logic [7:0] emit_ch;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0] ram_wdata, ram_rdata;

  tela_line_ram u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign acc      = s_tvalid & s_tready;
  assign c        = s_tdata;
  assign out_free = !out_valid || m_tready;

  // shared decode of the incoming word
  always_comb begin
    cur_f    = left ? '0 : cur;
    len_f    = left ? '0 : len;
    tail     = (len_f >= cur_f) ? len_f - cur_f : '0;
    nn       = (num == 16'd0) ? 16'd1 : num;
    nm1      = nn - 16'd1;
    sumc     = {11'd0, cur_f} + {1'b0, nn};
    prod     = {1'b0, num, 3'b0} + {3'b0, num, 1'b0} + {16'd0, c[3:0]};
    np       = ({10'd0, tail} < nn) ? tail : nn[AW-1:0];
    room     = AW'(tela_pkg::LINE_CAP - 1) - len_f;
    ni       = ({10'd0, room} < nn) ? room : nn[AW-1:0];
    nx       = np;
    is_print = (c == tela_pkg::CH_TAB) || (c >= 8'h20 && c != tela_pkg::CH_DEL);
    ovf      = cur_f >= AW'(tela_pkg::KEEP_MAX);
    put_direct = acc && s_tuser == tela_pkg::CMD_DATA && mode != tela_pkg::MODE_ESC &&
                 mode != tela_pkg::MODE_CSI && mode != tela_pkg::MODE_OSC &&
                 mode != tela_pkg::MODE_OSC_ESC && c != tela_pkg::CH_ESC &&
                 is_print && !ovf;
    emit_ch  = (e < em_keep) ? ram_rdata : tela_pkg::wrap_char(4'(e - em_keep));
  end

  // next state and datapath
  always_comb begin
    state_next = state;  mode_next = mode;  len_next = len;  cur_next = cur;
    left_next = left;  num_next = num;  more_next = more;  priv_next = priv;
    e_next = e;  em_total_next = em_total;  em_keep_next = em_keep;
    pend_next = pend;  pend_char_next = pend_char;  single_kind_next = single_kind;
    mv_rd_next = mv_rd;  mv_wr_next = mv_wr;  mv_cnt_next = mv_cnt;  mv_dir_next = mv_dir;
    fl_ptr_next = fl_ptr;  fl_cnt_next = fl_cnt;
    out_valid_next = out_valid && !m_tready;
    out_last_next = out_last;  out_char_next = out_char;  out_kind_next = out_kind;

    unique case (state)
      tela_pkg::S_IDLE: begin
        if (acc) begin
          if (s_tuser == tela_pkg::CMD_FLUSH) begin
            if (!left && len != '0) begin
              em_total_next = len;  em_keep_next = len;  e_next = '0;
              pend_next = 1'b0;  state_next = tela_pkg::S_EMIT_RD;
            end
            len_next = '0;  cur_next = '0;  left_next = 1'b0;
            mode_next = tela_pkg::MODE_NORMAL;
          end else begin
            unique case (mode)
              tela_pkg::MODE_ESC: begin
                if (c == "[") begin
                  mode_next = tela_pkg::MODE_CSI;
                  num_next = '0;  more_next = 1'b0;  priv_next = 1'b0;
                end else if (c == "]") begin
                  mode_next = tela_pkg::MODE_OSC;
                end else if (c < 8'h20 || c > 8'h2f) begin
                  if (c == "8" || c == "D" || c == "M") left_next = 1'b1;
                  mode_next = tela_pkg::MODE_NORMAL;
                end
              end
              tela_pkg::MODE_CSI: begin
                if (c >= "0" && c <= "9" && !more) begin
                  num_next = (prod > 20'd65535) ? 16'hffff : prod[15:0];
                end else if (c == ";") begin
                  more_next = 1'b1;
                end else if (c == "?") begin
                  priv_next = 1'b1;
                end else if (c >= 8'h40 && c <= 8'h7e) begin
                  mode_next = tela_pkg::MODE_NORMAL;
                  if (c == "A" || c == "B" || c == "E" || c == "F" || c == "H" ||
                      c == "J" || c == "S" || c == "T" || c == "d" || c == "f" ||
                      c == "r") begin
                    left_next = 1'b1;
                  end else if (c == "K" || c == "C" || c == "D" || c == "G" ||
                               c == "P" || c == "@" || c == "X") begin
                    left_next = 1'b0;  len_next = len_f;  cur_next = cur_f;
                  end
                  if (c == "K") begin
                    len_next = cur_f;
                  end else if (c == "C") begin
                    cur_next = (sumc > {11'd0, len_f}) ? len_f : sumc[AW-1:0];
                  end else if (c == "D") begin
                    cur_next = (nn > {10'd0, cur_f}) ? '0 : cur_f - nn[AW-1:0];
                  end else if (c == "G") begin
                    cur_next = (nm1 > {10'd0, len_f}) ? len_f : nm1[AW-1:0];
                  end else if (c == "P") begin
                    len_next = len_f - np;
                    if (tail != np) begin
                      mv_rd_next = cur_f + np;  mv_wr_next = cur_f;
                      mv_cnt_next = tail - np;  mv_dir_next = 1'b0;
                      state_next = tela_pkg::S_MV_RD;
                    end
                  end else if (c == "@") begin
                    len_next = len_f + ni;
                    fl_ptr_next = cur_f;  fl_cnt_next = ni;
                    if (ni != '0) begin
                      if (tail != '0) begin
                        mv_rd_next = len_f - AW'(1);  mv_wr_next = len_f - AW'(1) + ni;
                        mv_cnt_next = tail;  mv_dir_next = 1'b1;
                        state_next = tela_pkg::S_MV_RD;
                      end else begin
                        state_next = tela_pkg::S_FILL;
                      end
                    end
                  end else if (c == "X") begin
                    fl_ptr_next = cur_f;  fl_cnt_next = nx;
                    if (nx != '0) state_next = tela_pkg::S_FILL;
                  end else if (c == "h" && fs_en && priv &&
                               (num == 16'd1049 || num == 16'd1047 ||
                                num == 16'd47 || num == 16'd1004)) begin
                    single_kind_next = tela_pkg::KIND_FULL;
                    state_next = tela_pkg::S_SINGLE;
                  end
                end
              end
              tela_pkg::MODE_OSC: begin
                if (c == tela_pkg::CH_BEL) mode_next = tela_pkg::MODE_NORMAL;
                else if (c == tela_pkg::CH_ESC) mode_next = tela_pkg::MODE_OSC_ESC;
              end
              tela_pkg::MODE_OSC_ESC: begin
                if (c == "\\") mode_next = tela_pkg::MODE_NORMAL;
                else if (c != tela_pkg::CH_ESC) mode_next = tela_pkg::MODE_OSC;
              end
              default: begin
                mode_next = tela_pkg::MODE_NORMAL;
                if (c == tela_pkg::CH_ESC) begin
                  mode_next = tela_pkg::MODE_ESC;
                end else if (c == tela_pkg::CH_LF) begin
                  if (!left) begin
                    if (len == '0) begin
                      single_kind_next = tela_pkg::KIND_EMPTY;
                      state_next = tela_pkg::S_SINGLE;
                    end else begin
                      em_total_next = len;  em_keep_next = len;  e_next = '0;
                      pend_next = 1'b0;  state_next = tela_pkg::S_EMIT_RD;
                    end
                  end
                  len_next = '0;  cur_next = '0;  left_next = 1'b0;
                end else if (c == tela_pkg::CH_CR) begin
                  left_next = 1'b0;  len_next = len_f;  cur_next = '0;
                end else if (c == tela_pkg::CH_BS) begin
                  left_next = 1'b0;  len_next = len_f;
                  cur_next = (cur_f != '0) ? cur_f - AW'(1) : '0;
                end else if (is_print) begin
                  left_next = 1'b0;
                  if (ovf) begin
                    // emit kept content plus wrap mark, then write at column 0
                    em_keep_next = (len_f < AW'(tela_pkg::KEEP_MAX)) ?
                                   len_f : AW'(tela_pkg::KEEP_MAX);
                    em_total_next = ((len_f < AW'(tela_pkg::KEEP_MAX)) ?
                                     len_f : AW'(tela_pkg::KEEP_MAX)) +
                                    AW'(tela_pkg::MARK_LEN);
                    e_next = '0;  pend_next = 1'b1;  pend_char_next = c;
                    len_next = '0;  cur_next = '0;
                    state_next = tela_pkg::S_EMIT_RD;
                  end else begin
                    cur_next = cur_f + AW'(1);
                    len_next = (cur_f + AW'(1) > len_f) ? cur_f + AW'(1) : len_f;
                  end
                end
              end
            endcase
          end
        end
      end
      tela_pkg::S_EMIT_RD: state_next = tela_pkg::S_EMIT_PUSH;
      tela_pkg::S_EMIT_PUSH: begin
        if (out_free) begin
          out_valid_next = 1'b1;  out_kind_next = tela_pkg::KIND_CHAR;
          out_char_next = emit_ch;  out_last_next = (e == em_total - AW'(1));
          e_next = e + AW'(1);
          if (e == em_total - AW'(1))
            state_next = pend ? tela_pkg::S_POST : tela_pkg::S_IDLE;
          else
            state_next = tela_pkg::S_EMIT_RD;
        end
      end
      tela_pkg::S_SINGLE: begin
        if (out_free) begin
          out_valid_next = 1'b1;  out_kind_next = single_kind;
          out_char_next = 8'h00;  out_last_next = 1'b1;
          state_next = tela_pkg::S_IDLE;
        end
      end
      tela_pkg::S_POST: begin
        cur_next = AW'(1);  len_next = AW'(1);  pend_next = 1'b0;
        state_next = tela_pkg::S_IDLE;
      end
      tela_pkg::S_MV_RD: state_next = tela_pkg::S_MV_WR;
      tela_pkg::S_MV_WR: begin
        mv_rd_next = mv_dir ? mv_rd - AW'(1) : mv_rd + AW'(1);
        mv_wr_next = mv_dir ? mv_wr - AW'(1) : mv_wr + AW'(1);
        mv_cnt_next = mv_cnt - AW'(1);
        if (mv_cnt == AW'(1))
          state_next = mv_dir ? tela_pkg::S_FILL : tela_pkg::S_IDLE;
        else
          state_next = tela_pkg::S_MV_RD;
      end
      tela_pkg::S_FILL: begin
        fl_ptr_next = fl_ptr + AW'(1);  fl_cnt_next = fl_cnt - AW'(1);
        if (fl_cnt == AW'(1)) state_next = tela_pkg::S_IDLE;
      end
      default: state_next = tela_pkg::S_IDLE;
    endcase
  end

  // store port and handshake outputs
  always_comb begin
    s_tready  = (state == tela_pkg::S_IDLE);
    cfg_ready = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = cur_f;
    ram_wdata = c;
    ram_raddr = e;
    unique case (state)
      tela_pkg::S_IDLE: ram_we = put_direct;
      tela_pkg::S_POST: begin
        ram_we = 1'b1;  ram_waddr = '0;  ram_wdata = pend_char;
      end
      tela_pkg::S_MV_RD: ram_raddr = mv_rd;
      tela_pkg::S_MV_WR: begin
        ram_we = 1'b1;  ram_waddr = mv_wr;  ram_wdata = ram_rdata;
      end
      tela_pkg::S_FILL: begin
        ram_we = 1'b1;  ram_waddr = fl_ptr;  ram_wdata = " ";
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_char;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tela_pkg::S_IDLE;  mode <= tela_pkg::MODE_NORMAL;
      len <= '0;  cur <= '0;  left <= 1'b0;
      num <= '0;  more <= 1'b0;  priv <= 1'b0;
      fs_en <= 1'b1;  pend <= 1'b0;  out_valid <= 1'b0;
    end else begin
      state <= state_next;  mode <= mode_next;
      len <= len_next;  cur <= cur_next;  left <= left_next;
      num <= num_next;  more <= more_next;  priv <= priv_next;
      pend <= pend_next;  out_valid <= out_valid_next;
      if (cfg_valid && cfg_ready) fs_en <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    e <= e_next;  em_total <= em_total_next;  em_keep <= em_keep_next;
    pend_char <= pend_char_next;  single_kind <= single_kind_next;
    mv_rd <= mv_rd_next;  mv_wr <= mv_wr_next;  mv_cnt <= mv_cnt_next;
    mv_dir <= mv_dir_next;  fl_ptr <= fl_ptr_next;  fl_cnt <= fl_cnt_next;
    out_last <= out_last_next;  out_char <= out_char_next;  out_kind <= out_kind_next;
  end
endmodule
`default_nettype wire

>>> tb/terminal_escape_line_assembler_tb.sv
// Self-checking testbench for the terminal escape stripper and line assembler.
`default_nettype none
module terminal_escape_line_assembler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       last;
  } line_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic       s_tuser = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;

  terminal_escape_line_assembler DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic            fs_enable;
  tela_pkg::mode_t pmode;
  logic [7:0]      lstore [tela_pkg::LINE_CAP];
  int              llen, ccol;
  logic            left_line;
  int              csi_num;
  logic            csi_cont, csi_qmark;

  line_word_t expected_words[$];
  line_word_t step_words[$];
  int  errors = 0;
  int  send_idle_pct = 0, recv_idle_pct = 0;
  bit  recv_hold = 0;
  int  idle_cycles = 0;
  localparam int WATCHDOG = 20000;

  function automatic void push_word(logic [1:0] k, logic [7:0] c);
    line_word_t w;
    if (step_words.size() >= 63) return;
    w.kind = k; w.ch = c; w.last = 1'b0;
    step_words.push_back(w);
  endfunction

  function automatic void emit_line();
    int n;
    n = llen > tela_pkg::LINE_CAP - 1 ? tela_pkg::LINE_CAP - 1 : llen;
    if (n == 0) push_word(tela_pkg::KIND_EMPTY, 8'h00);
    for (int i = 0; i < n; i++) push_word(tela_pkg::KIND_CHAR, lstore[i]);
    llen = 0; ccol = 0;
  endfunction

  function automatic void fresh_line();
    if (left_line) begin
      llen = 0; ccol = 0; left_line = 1'b0;
    end
  endfunction

  function automatic void put_char(logic [7:0] c);
    int keep;
    fresh_line();
    if (ccol >= tela_pkg::LINE_CAP - tela_pkg::MARK_LEN - 1) begin
      keep = llen < tela_pkg::KEEP_MAX ? llen : tela_pkg::KEEP_MAX;
      for (int i = 0; i < keep; i++) push_word(tela_pkg::KIND_CHAR, lstore[i]);
      for (int i = 0; i < tela_pkg::MARK_LEN; i++)
        push_word(tela_pkg::KIND_CHAR, tela_pkg::wrap_char(4'(i)));
      llen = 0; ccol = 0;
    end
    lstore[ccol % tela_pkg::LINE_CAP] = c;
    ccol++;
    if (ccol > llen) llen = ccol;
  endfunction

  function automatic void csi_end(logic [7:0] c);
    int nn, tail, room;
    nn = csi_num > 0 ? csi_num : 1;
    if (c inside {"A", "B", "E", "F", "H", "J", "S", "T", "d", "f", "r"}) left_line = 1'b1;
    else if (c inside {"K", "C", "D", "G", "P", "@", "X"}) fresh_line();
    tail = llen >= ccol ? llen - ccol : 0;
    case (c)
      "K": llen = ccol;
      "C": ccol = ccol + nn > llen ? llen : ccol + nn;
      "D": ccol = nn > ccol ? 0 : ccol - nn;
      "G": ccol = nn - 1 > llen ? llen : nn - 1;
      "P": begin
        if (nn > tail) nn = tail;
        for (int i = 0; i + nn < tail; i++)
          lstore[(ccol + i) % tela_pkg::LINE_CAP] = lstore[(ccol + i + nn) % tela_pkg::LINE_CAP];
        llen -= nn;
      end
      "@": begin
        room = llen < tela_pkg::LINE_CAP - 1 ? tela_pkg::LINE_CAP - 1 - llen : 0;
        if (nn > room) nn = room;
        for (int i = tail; i > 0; i--)
          lstore[(ccol + nn + i - 1) % tela_pkg::LINE_CAP] =
            lstore[(ccol + i - 1) % tela_pkg::LINE_CAP];
        for (int i = 0; i < nn; i++) lstore[(ccol + i) % tela_pkg::LINE_CAP] = " ";
        llen += nn;
      end
      "X": begin
        if (nn > tail) nn = tail;
        for (int i = 0; i < nn; i++) lstore[(ccol + i) % tela_pkg::LINE_CAP] = " ";
      end
      default: ;
    endcase
    pmode = tela_pkg::MODE_NORMAL;
    if (fs_enable && c == "h" && csi_qmark && csi_num inside {1049, 1047, 47, 1004})
      push_word(tela_pkg::KIND_FULL, 8'h00);
  endfunction

  function automatic void predict_byte(logic cmd, logic [7:0] c);
    step_words.delete();
    if (cmd == tela_pkg::CMD_FLUSH) begin
      if (left_line) begin
        llen = 0; ccol = 0;
      end else if (llen > 0) emit_line();
      left_line = 1'b0;
      pmode = tela_pkg::MODE_NORMAL;
    end else begin
      case (pmode)
        tela_pkg::MODE_ESC:
          if (c == "[") begin
            pmode = tela_pkg::MODE_CSI; csi_num = 0; csi_cont = 0; csi_qmark = 0;
          end else if (c == "]") pmode = tela_pkg::MODE_OSC;
          else if (c < 8'h20 || c > 8'h2f) begin
            if (c inside {"8", "D", "M"}) left_line = 1'b1;
            pmode = tela_pkg::MODE_NORMAL;
          end
        tela_pkg::MODE_CSI:
          if (c >= "0" && c <= "9" && !csi_cont) begin
            csi_num = csi_num * 10 + (c - "0");
            if (csi_num > 65535) csi_num = 65535;
          end else if (c == ";") csi_cont = 1'b1;
          else if (c == "?") csi_qmark = 1'b1;
          else if (c >= 8'h40 && c <= 8'h7e) csi_end(c);
        tela_pkg::MODE_OSC:
          if (c == tela_pkg::CH_BEL) pmode = tela_pkg::MODE_NORMAL;
          else if (c == tela_pkg::CH_ESC) pmode = tela_pkg::MODE_OSC_ESC;
        tela_pkg::MODE_OSC_ESC:
          if (c == "\\") pmode = tela_pkg::MODE_NORMAL;
          else if (c != tela_pkg::CH_ESC) pmode = tela_pkg::MODE_OSC;
        default: begin
          pmode = tela_pkg::MODE_NORMAL;
          if (c == tela_pkg::CH_ESC) pmode = tela_pkg::MODE_ESC;
          else if (c == tela_pkg::CH_LF) begin
            if (left_line) fresh_line();
            else emit_line();
          end else if (c == tela_pkg::CH_CR) begin
            fresh_line(); ccol = 0;
          end else if (c == tela_pkg::CH_BS) begin
            fresh_line();
            if (ccol > 0) ccol--;
          end else if (c == tela_pkg::CH_TAB || (c >= 8'h20 && c != tela_pkg::CH_DEL))
            put_char(c);
        end
      endcase
    end
    if (step_words.size() > 0) step_words[$].last = 1'b1;
    foreach (step_words[i]) expected_words.push_back(step_words[i]);
  endfunction

  // tvalid stays up after a handshake; the next word or an idle cycle replaces it
  task automatic send_byte(logic cmd, logic [7:0] b);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1; s_tuser <= cmd; s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_byte(cmd, b);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(tela_pkg::CMD_DATA, s[i]);
  endtask

  task automatic drain();
    int n = 0;
    s_tvalid <= 1'b0;
    while (expected_words.size() > 0) @(posedge clk);
    // a byte with no result may still be in flight
    while (n < 300) begin
      @(posedge clk); n++;
    end
  endtask

  task automatic write_fs_enable(logic v);
    cfg_valid <= 1'b1; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    fs_enable = v;
  endtask

  // receiver
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !recv_hold && !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
  end

  // checker
  always @(posedge clk) begin
    line_word_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word kind=%0d char=%0h", m_tuser, m_tdata);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (m_tuser !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, m_tuser); errors++;
        end
        if (m_tdata !== e.ch) begin
          $error("line_char exp %0h got %0h", e.ch, m_tdata); errors++;
        end
        if (m_tlast !== e.last) begin
          $error("last_of_run exp %0d got %0d", e.last, m_tlast); errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_text_edits();
    send_text("hello\tworld\r");
    send_text("HE\010\010xy\n");
    send_byte(tela_pkg::CMD_DATA, tela_pkg::CH_LF);
    send_text(string'({"abcdef", tela_pkg::CH_ESC, "[3D", tela_pkg::CH_ESC, "[2P",
                       tela_pkg::CH_ESC, "[0@", tela_pkg::CH_ESC, "[X"}));
    send_text(string'({tela_pkg::CH_ESC, "[G", tela_pkg::CH_ESC, "[99C", tela_pkg::CH_ESC,
                       "[K", 8'h01, tela_pkg::CH_DEL, 8'hff, 8'h80, "\n"}));
  endtask

  task automatic test_sequences();
    send_text(string'({"ab", tela_pkg::CH_ESC, "[5A", "q\n"}));
    send_text(string'({"cd", tela_pkg::CH_ESC, "M", "\n", tela_pkg::CH_ESC, "(B", "z"}));
    send_text(string'({tela_pkg::CH_ESC, "]0;title", tela_pkg::CH_BEL, tela_pkg::CH_ESC, "]x",
                       tela_pkg::CH_ESC, tela_pkg::CH_ESC, "\\", "k\n"}));
    send_text(string'({tela_pkg::CH_ESC, "[?1049h", tela_pkg::CH_ESC, "[?47;5h",
                       tela_pkg::CH_ESC, "[?1004h", tela_pkg::CH_ESC, "[?1047h"}));
    send_text(string'({tela_pkg::CH_ESC, "[999999C", tela_pkg::CH_ESC, "[?1049l"}));
    send_byte(tela_pkg::CMD_FLUSH, 8'h00);
    send_text(string'({"zz", tela_pkg::CH_ESC, "[H"}));
    send_byte(tela_pkg::CMD_FLUSH, 8'hff);
    send_byte(tela_pkg::CMD_FLUSH, 8'h00);
  endtask

  task automatic test_overflow();
    for (int i = 0; i < 60; i++) send_byte(tela_pkg::CMD_DATA, 8'("a" + (i % 26)));
    send_text(string'({tela_pkg::CH_ESC, "[1G", tela_pkg::CH_ESC, "[80@"}));
    send_byte(tela_pkg::CMD_FLUSH, 8'h00);
  endtask

  task automatic test_detect_disable();
    write_fs_enable(1'b0);
    send_text(string'({tela_pkg::CH_ESC, "[?1049h", "q\n"}));
  endtask

  task automatic test_backpressure();
    recv_hold = 1;
    fork
      begin
        int n = 0;
        while (n < 400) begin
          @(posedge clk); n++;
        end
        recv_hold = 0;
      end
      for (int i = 0; i < 20; i++) send_text("xy\n");
    join
    drain();
  endtask

  function automatic logic [7:0] rand_byte();
    int r = $urandom_range(99, 0);
    if (r < 50) return 8'($urandom_range(8'h7e, 8'h20));
    if (r < 58) return tela_pkg::CH_LF;
    if (r < 62) return tela_pkg::CH_CR;
    if (r < 65) return tela_pkg::CH_BS;
    if (r < 80) return tela_pkg::CH_ESC;
    if (r < 88) return "[";
    if (r < 94) return 8'($urandom_range("9", "0"));
    return 8'($urandom_range(255, 0));
  endfunction

  task automatic test_random(int count);
    string finals = "KCDGP@XABEFHJSTdfrhm";
    int j;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3, 0) == 0) begin
        send_byte(tela_pkg::CMD_DATA, tela_pkg::CH_ESC);
        send_byte(tela_pkg::CMD_DATA, "[");
        if ($urandom_range(1, 0)) send_byte(tela_pkg::CMD_DATA, "?");
        send_byte(tela_pkg::CMD_DATA, 8'($urandom_range("9", "0")));
        if ($urandom_range(1, 0)) send_byte(tela_pkg::CMD_DATA, 8'($urandom_range("9", "0")));
        j = $urandom_range(finals.len() - 1, 0);
        send_byte(tela_pkg::CMD_DATA, finals[j]);
        i += 3;
      end else if ($urandom_range(49, 0) == 0) send_byte(1'($urandom_range(1, 0)), rand_byte());
      else send_byte(tela_pkg::CMD_DATA, rand_byte());
    end
  endtask

  initial begin
    fs_enable = 1; pmode = tela_pkg::MODE_NORMAL; llen = 0; ccol = 0; left_line = 0;
    csi_num = 0; csi_cont = 0; csi_qmark = 0;
    foreach (lstore[i]) lstore[i] = 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_text_edits();
    test_sequences();
    test_overflow();
    drain();
    test_detect_disable();
    test_backpressure();
    send_idle_pct = 21; recv_idle_pct = 88;
    test_random(35);
    drain();
    write_fs_enable(1'b1);
    send_idle_pct = 88; recv_idle_pct = 21;
    test_random(35);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(35);
    send_byte(tela_pkg::CMD_FLUSH, 8'h00);
    drain();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
